// ----- sv/rhp_pkg.sv -----
// Shared types and constants for the resources header parser.
// No dependencies; every other file imports this package.
package rhp_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'hBEEFCACE;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_NEG_LEN   = 2'd3;

    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_NRT       = 4'd1,
        PH_SRT       = 4'd2,
        PH_SKIPRT    = 4'd3,
        PH_VERSION   = 4'd4,
        PH_RESCOUNT  = 4'd5,
        PH_TYPECOUNT = 4'd6,
        PH_TYPELEN   = 4'd7,
        PH_TYPESKIP  = 4'd8,
        PH_ALIGN     = 4'd9,
        PH_HASHES    = 4'd10,
        PH_NAMEPOS   = 4'd11,
        PH_DSO       = 4'd12,
        PH_DONE      = 4'd13
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] version;
        logic [31:0] resource_count;
        logic [31:0] type_count;
        logic [31:0] types_offset;
        logic [31:0] name_offsets_offset;
        logic [31:0] names_offset;
        logic [31:0] data_section_offset;
    } result_t;

endpackage

// ----- sv/rhp_core.sv -----
// Header parsing state machine: consumes one byte per accepted item.
// Depends on rhp_pkg for the phase enum, status codes and item types.
module rhp_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  rhp_pkg::item_t item,
    output logic           res_load,
    output rhp_pkg::result_t res
);
    import rhp_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             idx_reg, idx_next;
    logic [31:0]            word_reg, word_next;
    logic [34:0]            skip_reg, skip_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [31:0]            types_left_reg, types_left_next;
    logic [31:0]            varint_reg, varint_next;
    logic [4:0]             shift_reg, shift_next;
    logic [31:0]            version_reg, version_next;
    logic [31:0]            rescount_reg, rescount_next;
    logic [31:0]            typecount_reg, typecount_next;
    logic [OFFSET_BITS-1:0] types_off_reg, types_off_next;
    logic [OFFSET_BITS-1:0] nameoff_reg, nameoff_next;

    logic                   emit;
    logic [1:0]             emit_status;
    logic [OFFSET_BITS-1:0] emit_names;
    logic [31:0]            emit_dso;
    logic [31:0]            held_version;
    logic [31:0]            held_rescount;
    logic [31:0]            held_typecount;
    logic [OFFSET_BITS-1:0] held_types_off;
    logic [OFFSET_BITS-1:0] held_nameoff;

    // Next state. A phase that finishes on this byte hands over a target
    // phase; the entry chain then passes over any empty skips at once.
    always_comb
    begin
        phase_t      target;
        logic        do_enter;
        logic [31:0] vv;
        logic [31:0] wa;

        phase_next      = phase_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        skip_next       = skip_reg;
        pos_next        = pos_reg;
        types_left_next = types_left_reg;
        varint_next     = varint_reg;
        shift_next      = shift_reg;
        version_next    = version_reg;
        rescount_next   = rescount_reg;
        typecount_next  = typecount_reg;
        types_off_next  = types_off_reg;
        nameoff_next    = nameoff_reg;
        emit            = 1'b0;
        emit_status     = ST_OK;
        emit_names      = '0;
        emit_dso        = '0;
        target          = phase_reg;
        do_enter        = 1'b0;
        vv              = varint_reg | (32'(item.data_byte[6:0]) << shift_reg);
        wa              = word_reg | (32'(item.data_byte) << {idx_reg, 3'b000});

        if (accept && phase_reg != PH_DONE)
        begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                PH_SKIPRT, PH_TYPESKIP, PH_ALIGN, PH_HASHES, PH_NAMEPOS:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_next == '0)
                    begin
                        do_enter = 1'b1;
                        unique case (phase_reg)
                            PH_SKIPRT: target = PH_VERSION;
                            PH_TYPESKIP:
                            begin
                                types_left_next = types_left_reg - 1'b1;
                                target          = PH_TYPELEN;
                            end
                            PH_ALIGN:  target = PH_HASHES;
                            PH_HASHES: target = PH_NAMEPOS;
                            default:   target = PH_DSO;
                        endcase
                    end
                end
                PH_TYPELEN:
                begin
                    varint_next = vv;
                    shift_next  = shift_reg + 5'd7;
                    if (!item.data_byte[7])
                    begin
                        if (vv[31])
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NEG_LEN;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            skip_next = 35'(vv);
                            target    = PH_TYPESKIP;
                            do_enter  = 1'b1;
                        end
                    end
                end
                default:
                begin
                    word_next = wa;
                    idx_next  = idx_reg + 1'b1;
                    if (idx_next == 2'd0)
                    begin
                        unique case (phase_reg)
                            PH_MAGIC:
                            begin
                                if (wa != MAGIC_WORD)
                                begin
                                    emit        = 1'b1;
                                    emit_status = ST_BAD_MAGIC;
                                    phase_next  = PH_DONE;
                                end
                                else
                                begin
                                    target   = PH_NRT;
                                    do_enter = 1'b1;
                                end
                            end
                            PH_NRT:
                            begin
                                target   = PH_SRT;
                                do_enter = 1'b1;
                            end
                            PH_SRT:
                            begin
                                skip_next = 35'(wa);
                                target    = PH_SKIPRT;
                                do_enter  = 1'b1;
                            end
                            PH_VERSION:
                            begin
                                version_next = wa;
                                target       = PH_RESCOUNT;
                                do_enter     = 1'b1;
                            end
                            PH_RESCOUNT:
                            begin
                                rescount_next = wa;
                                target        = PH_TYPECOUNT;
                                do_enter      = 1'b1;
                            end
                            PH_TYPECOUNT:
                            begin
                                typecount_next  = wa;
                                types_left_next = wa;
                                types_off_next  = pos_next;
                                target          = PH_TYPELEN;
                                do_enter        = 1'b1;
                            end
                            default:
                            begin
                                emit        = 1'b1;
                                emit_status = ST_OK;
                                emit_names  = pos_next;
                                emit_dso    = wa;
                                phase_next  = PH_DONE;
                            end
                        endcase
                    end
                end
            endcase

            // Entry chain; every step only moves forward, so one pass suffices.
            if (do_enter)
            begin
                if (target == PH_SKIPRT && skip_next == '0)
                    target = PH_VERSION;
                if (target == PH_TYPESKIP && skip_next == '0)
                begin
                    types_left_next = types_left_next - 1'b1;
                    target          = PH_TYPELEN;
                end
                if (target == PH_TYPELEN)
                begin
                    if (types_left_next == '0)
                        target = PH_ALIGN;
                    else
                    begin
                        varint_next = '0;
                        shift_next  = '0;
                    end
                end
                if (target == PH_ALIGN)
                begin
                    skip_next = 35'(3'(3'd0 - pos_next[2:0]));
                    if (skip_next == '0)
                        target = PH_HASHES;
                end
                if (target == PH_HASHES)
                begin
                    skip_next = 35'({rescount_next, 2'b00});
                    if (skip_next == '0)
                        target = PH_NAMEPOS;
                end
                if (target == PH_NAMEPOS)
                begin
                    nameoff_next = pos_next;
                    skip_next    = 35'({rescount_next, 2'b00});
                    if (skip_next == '0)
                        target = PH_DSO;
                end
                phase_next = target;
                idx_next   = '0;
                word_next  = '0;
            end

            if (item.last_byte && !emit)
            begin
                emit        = 1'b1;
                emit_status = ST_TRUNCATED;
            end
        end

        // The result reports header fields as updated by this byte.
        held_version   = version_next;
        held_rescount  = rescount_next;
        held_typecount = typecount_next;
        held_types_off = types_off_next;
        held_nameoff   = nameoff_next;

        // The last byte of a buffer rearms the parser.
        if (accept && item.last_byte)
        begin
            phase_next      = PH_MAGIC;
            idx_next        = '0;
            word_next       = '0;
            skip_next       = '0;
            pos_next        = '0;
            types_left_next = '0;
            varint_next     = '0;
            shift_next      = '0;
            version_next    = '0;
            rescount_next   = '0;
            typecount_next  = '0;
            types_off_next  = '0;
            nameoff_next    = '0;
        end
    end

    // Result assembly.
    always_comb
    begin
        res_load                = emit;
        res.status              = emit_status;
        res.version             = held_version;
        res.resource_count      = held_rescount;
        res.type_count          = held_typecount;
        res.types_offset        = 32'(held_types_off);
        res.name_offsets_offset = 32'(held_nameoff);
        res.names_offset        = 32'(emit_names);
        res.data_section_offset = emit_dso;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            idx_reg        <= '0;
            word_reg       <= '0;
            skip_reg       <= '0;
            pos_reg        <= '0;
            types_left_reg <= '0;
            varint_reg     <= '0;
            shift_reg      <= '0;
            version_reg    <= '0;
            rescount_reg   <= '0;
            typecount_reg  <= '0;
            types_off_reg  <= '0;
            nameoff_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            word_reg       <= word_next;
            skip_reg       <= skip_next;
            pos_reg        <= pos_next;
            types_left_reg <= types_left_next;
            varint_reg     <= varint_next;
            shift_reg      <= shift_next;
            version_reg    <= version_next;
            rescount_reg   <= rescount_next;
            typecount_reg  <= typecount_next;
            types_off_reg  <= types_off_next;
            nameoff_reg    <= nameoff_next;
        end
    end

endmodule

// ----- sv/rhp_out_reg.sv -----
// Result register with valid/stall handshake toward the consumer.
// Depends on rhp_pkg for the result type.
module rhp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rhp_pkg::result_t load_data,
    input  logic             out_stall,
    output logic             out_valid,
    output rhp_pkg::result_t out_item,
    output logic             full_blocked
);
    import rhp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid    = valid_reg;
    assign out_item     = data_reg;
    // A held result that is not being taken blocks the next byte.
    assign full_blocked = valid_reg & out_stall;

endmodule

// ----- sv/resource_header_parser.sv -----
// Top level of the resources header parser.
// Depends on rhp_pkg, rhp_core and rhp_out_reg.
//
//   channel | direction | payload  | handshake
//   --------+-----------+----------+------------------------------------
//   in      | input     | item_t   | in_valid, in_stall (driven here)
//   out     | output    | result_t | out_valid (driven here), out_stall
//
// The parser state updates at the edge that accepts a byte item, and
// any result lands in the output register at that same edge.
// A new byte is accepted in every cycle unless a result sits in the
// output register while the consumer stalls it.
// Reset is asynchronous and active low; it returns the parser to the
// magic-word phase and empties the output register.
module resource_header_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rhp_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output rhp_pkg::result_t out_item
);
    import rhp_pkg::*;

    logic    accept;
    logic    res_load;
    result_t res;
    logic    blocked;

    // An item is taken whenever the output slot is free or being drained.
    assign in_stall = blocked;
    assign accept   = in_valid & ~blocked;

    // The core walks the header phases one byte at a time and flags the
    // byte at which the outcome (good, bad magic, bad length, truncated)
    // becomes known.
    rhp_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (in_item),
        .res_load (res_load),
        .res      (res)
    );

    // The output register holds a finished result until the consumer
    // takes it.
    rhp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .load_data    (res),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_item     (out_item),
        .full_blocked (blocked)
    );

endmodule
